@@ hdl/htacc_pkg.sv @@
// ============================================================================
// htacc_pkg
// Shared types, widths and the Q16.16 saturating accumulate step for the
// hierarchical transform accumulator.
// ============================================================================
package htacc_pkg;

    localparam int LANES   = 4;
    localparam int DATA_W  = 32;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int FRAC_W  = 16;
    localparam int SHIFT_W = PROD_W - FRAC_W;
    localparam int SUM_W   = SHIFT_W + 1;
    localparam int BONE_W  = 7;
    localparam int PAR_W   = 8;
    localparam int COL_W   = 2;

    localparam logic signed [SUM_W-1:0] SAT_HI = {{(SUM_W-DATA_W+1){1'b0}},
                                                  {(DATA_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO = {{(SUM_W-DATA_W+1){1'b1}},
                                                  {(DATA_W-1){1'b0}}};

    typedef logic signed [DATA_W-1:0] elem_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef elem_t vec_t [LANES];

    typedef struct packed {
        logic              valid;
        logic              root;
        logic              pvalid;
        logic              wr_ok;
        logic [BONE_W-1:0] bone;
        logic [COL_W-1:0]  col;
    } ctl_t;

    typedef struct packed {
        elem_t val;
        logic  ovf;
    } sat_t;

    // acc + (prod >>> 16), clamped to 32 bits
    function automatic sat_t sat_add(input elem_t acc, input prod_t prod);
        logic signed [SUM_W-1:0] sum;
        sat_t                    res;
        sum = SUM_W'(acc) + SUM_W'(prod >>> FRAC_W);
        if (sum > SAT_HI)
        begin
            res.val = SAT_HI[DATA_W-1:0];
            res.ovf = 1'b1;
        end
        else if (sum < SAT_LO)
        begin
            res.val = SAT_LO[DATA_W-1:0];
            res.ovf = 1'b1;
        end
        else
        begin
            res.val = sum[DATA_W-1:0];
            res.ovf = 1'b0;
        end
        return res;
    endfunction

endpackage

@@ hdl/htacc_in_if.sv @@
// ============================================================================
// htacc_in_if
// Request channel: one local matrix column with bone, parent and column index.
// ============================================================================
interface htacc_in_if;

    logic                                valid;
    logic                                ready;
    logic [htacc_pkg::BONE_W-1:0]        bone;
    logic signed [htacc_pkg::PAR_W-1:0]  parent;
    logic [htacc_pkg::COL_W-1:0]         column;
    logic signed [htacc_pkg::DATA_W-1:0] local_0;
    logic signed [htacc_pkg::DATA_W-1:0] local_1;
    logic signed [htacc_pkg::DATA_W-1:0] local_2;
    logic signed [htacc_pkg::DATA_W-1:0] local_3;

    modport source (
        output valid, bone, parent, column, local_0, local_1, local_2, local_3,
        input  ready
    );

    modport sink (
        input  valid, bone, parent, column, local_0, local_1, local_2, local_3,
        output ready
    );

endinterface

@@ hdl/htacc_out_if.sv @@
// ============================================================================
// htacc_out_if
// Result channel: one world matrix column with its overflow flag.
// ============================================================================
interface htacc_out_if;

    logic                                valid;
    logic                                ready;
    logic [htacc_pkg::BONE_W-1:0]        out_bone;
    logic [htacc_pkg::COL_W-1:0]         out_column;
    logic signed [htacc_pkg::DATA_W-1:0] world_0;
    logic signed [htacc_pkg::DATA_W-1:0] world_1;
    logic signed [htacc_pkg::DATA_W-1:0] world_2;
    logic signed [htacc_pkg::DATA_W-1:0] world_3;
    logic                                overflow;

    modport source (
        output valid, out_bone, out_column, world_0, world_1, world_2, world_3,
               overflow,
        input  ready
    );

    modport sink (
        input  valid, out_bone, out_column, world_0, world_1, world_2, world_3,
               overflow,
        output ready
    );

endinterface

@@ hdl/htacc_ram.sv @@
// ============================================================================
// htacc_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module htacc_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 128,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/htacc_lane.sv @@
// ============================================================================
// htacc_lane
// One matrix row: holds that row of every world matrix (one RAM per column),
// multiplies the parent row by the local column and accumulates with
// saturation over two stages.
// ============================================================================
module htacc_lane #(
    parameter int  MAX_BONES = 128,
    localparam int AW        = $clog2(MAX_BONES)
) (
    input  logic             clk,
    input  logic             adv,
    input  logic [AW-1:0]    rd_addr,
    input  htacc_pkg::ctl_t  ctl_s2,
    input  htacc_pkg::vec_t  loc_s2,
    input  htacc_pkg::elem_t loc_row,
    input  htacc_pkg::ctl_t  ctl_s4,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    output htacc_pkg::elem_t result,
    output logic             ovf
);

    htacc_pkg::elem_t pe [htacc_pkg::LANES];
    htacc_pkg::prod_t prod_reg [htacc_pkg::LANES];
    htacc_pkg::elem_t loc_s3_reg;
    htacc_pkg::elem_t acc_reg;
    logic             acc_ovf_reg;
    htacc_pkg::prod_t p2_reg;
    htacc_pkg::prod_t p3_reg;
    htacc_pkg::elem_t loc_s4_reg;
    htacc_pkg::sat_t  s0;
    htacc_pkg::sat_t  s1;
    htacc_pkg::sat_t  s2;
    htacc_pkg::sat_t  s3;

    for (genvar k = 0; k < htacc_pkg::LANES; k++)
    begin : g_col
        htacc_ram #(
            .WIDTH (htacc_pkg::DATA_W),
            .DEPTH (MAX_BONES)
        ) u_ram (
            .clk   (clk),
            .we    (wr_en && (ctl_s4.col == htacc_pkg::COL_W'(k))),
            .waddr (wr_addr),
            .wdata (result),
            .re    (adv),
            .raddr (rd_addr),
            .rdata (pe[k])
        );
    end

    // stage 2: products
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < htacc_pkg::LANES; k++)
            begin
                prod_reg[k] <= ctl_s2.pvalid ?
                    htacc_pkg::prod_t'(pe[k]) * htacc_pkg::prod_t'(loc_s2[k]) : '0;
            end
            loc_s3_reg <= loc_row;
        end
    end

    // stage 3: first two accumulate steps
    always_comb
    begin
        s0 = htacc_pkg::sat_add('0, prod_reg[0]);
        s1 = htacc_pkg::sat_add(s0.val, prod_reg[1]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            acc_reg     <= s1.val;
            acc_ovf_reg <= s0.ovf | s1.ovf;
            p2_reg      <= prod_reg[2];
            p3_reg      <= prod_reg[3];
            loc_s4_reg  <= loc_s3_reg;
        end
    end

    // stage 4: last two accumulate steps, root pass-through
    always_comb
    begin
        s2 = htacc_pkg::sat_add(acc_reg, p2_reg);
        s3 = htacc_pkg::sat_add(s2.val, p3_reg);
    end

    assign result = ctl_s4.root ? loc_s4_reg : s3.val;
    assign ovf    = !ctl_s4.root && (acc_ovf_reg || s2.ovf || s3.ovf);

endmodule

@@ hdl/htacc_merge.sv @@
// ============================================================================
// htacc_merge
// Output register: gathers the four lane results into one world column and
// ORs the lane overflow flags.
// ============================================================================
module htacc_merge (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  htacc_pkg::ctl_t               ctl_s4,
    input  htacc_pkg::vec_t               lane_res,
    input  logic [htacc_pkg::LANES-1:0]   lane_ovf,
    htacc_out_if.source                   result
);

    logic                         valid_reg;
    logic [htacc_pkg::BONE_W-1:0] bone_reg;
    logic [htacc_pkg::COL_W-1:0]  col_reg;
    htacc_pkg::vec_t              world_reg;
    logic                         ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= ctl_s4.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && ctl_s4.valid)
        begin
            bone_reg  <= ctl_s4.bone;
            col_reg   <= ctl_s4.col;
            world_reg <= lane_res;
            ovf_reg   <= |lane_ovf;
        end
    end

    assign result.valid      = valid_reg;
    assign result.out_bone   = bone_reg;
    assign result.out_column = col_reg;
    assign result.world_0    = world_reg[0];
    assign result.world_1    = world_reg[1];
    assign result.world_2    = world_reg[2];
    assign result.world_3    = world_reg[3];
    assign result.overflow   = ovf_reg;

endmodule

@@ hdl/hierarchical_transform_accumulator.sv @@
// ============================================================================
// hierarchical_transform_accumulator
// World transform concatenation in Q16.16: world column = parent world
// matrix x local column, with four row lanes and a merging output register.
// ============================================================================
// Usage:
//   item   : request channel, one local column (bone, parent, column, rows).
//   result : one world column per request, in request order, with overflow.
//   A request with a negative parent is a root; its column passes through.
//   Throughput is one request per cycle while result is not stalled and no
//   parent is pending. A request whose parent is still in one of the four
//   compute stages waits until that bone's last column has been written to
//   the row RAMs; a bone's first column after its parent may therefore
//   wait, later columns do not.
//   Each lane owns four RAMs of MAX_BONES words (one row, one column each);
//   all sixteen are read at the parent index, four written per request.
//   The world store holds nothing meaningful after reset; only parents that
//   were already sent may be referenced.
//   When result is stalled the whole pipeline holds and item.ready drops;
//   the output register keeps its column until taken.
// ============================================================================
module hierarchical_transform_accumulator #(
    parameter int MAX_BONES = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    htacc_in_if.sink    item,
    htacc_out_if.source result
);

    localparam int AW     = $clog2(MAX_BONES);
    localparam int STAGES = 4;

    htacc_pkg::ctl_t              ctl_reg [STAGES];
    htacc_pkg::ctl_t              ctl_next;
    logic [AW-1:0]                par_reg;
    htacc_pkg::vec_t              loc_s1_reg;
    htacc_pkg::vec_t              loc_s2_reg;
    htacc_pkg::vec_t              loc_in;
    htacc_pkg::vec_t              lane_res;
    logic [htacc_pkg::LANES-1:0]  lane_ovf;
    logic                         adv;
    logic                         hazard;
    logic                         accept;
    logic                         wr_en;

    assign adv    = !result.valid || result.ready;
    assign accept = item.valid && item.ready;

    // parent still being computed
    always_comb
    begin
        hazard = 1'b0;
        for (int s = 0; s < STAGES; s++)
        begin
            if (ctl_reg[s].valid && !item.parent[htacc_pkg::PAR_W-1] &&
                (ctl_reg[s].bone == item.parent[htacc_pkg::BONE_W-1:0]))
            begin
                hazard = 1'b1;
            end
        end
    end

    assign item.ready = adv && !hazard;

    always_comb
    begin
        ctl_next.valid  = accept;
        ctl_next.root   = item.parent[htacc_pkg::PAR_W-1];
        ctl_next.pvalid = !item.parent[htacc_pkg::PAR_W-1] &&
                          (int'(item.parent[htacc_pkg::BONE_W-1:0]) < MAX_BONES);
        ctl_next.wr_ok  = int'(item.bone) < MAX_BONES;
        ctl_next.bone   = item.bone;
        ctl_next.col    = item.column;
    end

    assign loc_in[0] = item.local_0;
    assign loc_in[1] = item.local_1;
    assign loc_in[2] = item.local_2;
    assign loc_in[3] = item.local_3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < STAGES; s++)
            begin
                ctl_reg[s] <= '0;
            end
        end
        else if (adv)
        begin
            ctl_reg[0] <= ctl_next;
            for (int s = 1; s < STAGES; s++)
            begin
                ctl_reg[s] <= ctl_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            par_reg    <= AW'(item.parent[htacc_pkg::BONE_W-1:0]);
            loc_s1_reg <= loc_in;
            loc_s2_reg <= loc_s1_reg;
        end
    end

    assign wr_en = adv && ctl_reg[STAGES-1].valid && ctl_reg[STAGES-1].wr_ok;

    for (genvar r = 0; r < htacc_pkg::LANES; r++)
    begin : g_lane
        htacc_lane #(
            .MAX_BONES (MAX_BONES)
        ) u_lane (
            .clk     (clk),
            .adv     (adv),
            .rd_addr (par_reg),
            .ctl_s2  (ctl_reg[1]),
            .loc_s2  (loc_s2_reg),
            .loc_row (loc_s2_reg[r]),
            .ctl_s4  (ctl_reg[STAGES-1]),
            .wr_en   (wr_en),
            .wr_addr (AW'(ctl_reg[STAGES-1].bone)),
            .result  (lane_res[r]),
            .ovf     (lane_ovf[r])
        );
    end

    htacc_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .ctl_s4   (ctl_reg[STAGES-1]),
        .lane_res (lane_res),
        .lane_ovf (lane_ovf),
        .result   (result)
    );

endmodule

@@ hdl/htacc_chk.sv @@
// ============================================================================
// htacc_chk
// Port-level checks for the hierarchical transform accumulator.
// ============================================================================
module htacc_chk (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         item_valid,
    input logic                         item_ready,
    input logic [htacc_pkg::BONE_W-1:0] item_bone,
    input logic [htacc_pkg::PAR_W-1:0]  item_parent,
    input logic                         result_valid,
    input logic                         result_ready
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped while stalled");

    a_stall_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |-> !item_ready)
        else $error("request taken while result stalled");

    a_parent_wait: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=>
        !(item_valid && item_ready && !item_parent[htacc_pkg::PAR_W-1] &&
          (item_parent[htacc_pkg::BONE_W-1:0] == $past(item_bone))))
        else $error("child taken while parent column in flight");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !result_valid)
        else $error("result valid during reset");

endmodule

bind hierarchical_transform_accumulator htacc_chk u_htacc_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .item_bone    (item.bone),
    .item_parent  (item.parent),
    .result_valid (result.valid),
    .result_ready (result.ready)
);
